@@ rtl/mvsm_pkg.sv @@
package mvsm_pkg;

   localparam int NUM_VOICES       = 16;
   localparam int FRAMES_PER_VOICE = 4096;

   localparam int VOICE_W  = $clog2(NUM_VOICES);
   localparam int FIDX_W   = $clog2(FRAMES_PER_VOICE);
   localparam int FADDR_W  = VOICE_W + FIDX_W;
   localparam int CNT_W    = $clog2(NUM_VOICES + 1);

   // Field widths of the channel words and registers.
   localparam int MODE_W   = 4;
   localparam int VNUM_W   = 4;
   localparam int VALUE_W  = 13;
   localparam int FLAGS_W  = 3;
   localparam int SAMPLE_W = 16;
   localparam int STATUS_W = 2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;
   localparam int COUNT_W     = 5;
   localparam int GAIN_W      = 9;

   localparam logic [CSR_INDEX_W-1:0] CSR_VOICE_COUNT   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADD_TO_STREAM = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_PERCENT  = 2'd2;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 9'd100;

   localparam logic [MODE_W-1:0] MODE_WRITE    = 4'd0;
   localparam logic [MODE_W-1:0] MODE_LENGTH   = 4'd1;
   localparam logic [MODE_W-1:0] MODE_PLAY     = 4'd2;
   localparam logic [MODE_W-1:0] MODE_PAUSE    = 4'd3;
   localparam logic [MODE_W-1:0] MODE_RESUME   = 4'd4;
   localparam logic [MODE_W-1:0] MODE_STOP     = 4'd5;
   localparam logic [MODE_W-1:0] MODE_LOOP     = 4'd6;
   localparam logic [MODE_W-1:0] MODE_POSITION = 4'd7;
   localparam logic [MODE_W-1:0] MODE_QUERY    = 4'd8;
   localparam logic [MODE_W-1:0] MODE_RESET    = 4'd9;
   localparam logic [MODE_W-1:0] MODE_RENDER   = 4'd10;

   localparam int FLAG_IGNORE   = 0;
   localparam int FLAG_NOLOOP   = 1;
   localparam int FLAG_AUTOLOOP = 2;

   localparam logic [STATUS_W-1:0] STATUS_IDLE    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_PLAYING = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;

   localparam int GAIN_DIV = 100;
   // floor(2^32 / 100); the quotient it gives is low by at most one.
   localparam logic [25:0] GAIN_RECIP = 26'((64'd1 << 32) / GAIN_DIV);

   typedef struct packed {
      logic [VALUE_W-1:0] length;
      logic [VALUE_W-1:0] pos;
      logic               playing;
      logic               looping;
      logic [FLAGS_W-1:0] flags;
   } voice_entry_type;

endpackage

@@ rtl/mvsm_req_if.sv @@
interface mvsm_req_if;
   logic                                      valid;
   logic                                      ready;
   logic [mvsm_pkg::MODE_W-1:0]               mode;
   logic [mvsm_pkg::VNUM_W-1:0]               voice;
   logic [mvsm_pkg::VALUE_W-1:0]              value;
   logic [mvsm_pkg::FLAGS_W-1:0]              voice_flags;
   logic signed [mvsm_pkg::SAMPLE_W-1:0]      left_in;
   logic signed [mvsm_pkg::SAMPLE_W-1:0]      right_in;

   modport source (output valid, mode, voice, value, voice_flags, left_in, right_in,
                   input ready);
   modport sink (input valid, mode, voice, value, voice_flags, left_in, right_in,
                 output ready);
endinterface

@@ rtl/mvsm_rsp_if.sv @@
interface mvsm_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [mvsm_pkg::SAMPLE_W-1:0]      left_out;
   logic signed [mvsm_pkg::SAMPLE_W-1:0]      right_out;
   logic [mvsm_pkg::STATUS_W-1:0]             voice_status;
   logic [mvsm_pkg::VALUE_W-1:0]              voice_position;

   modport source (output valid, left_out, right_out, voice_status, voice_position,
                   input ready);
   modport sink (input valid, left_out, right_out, voice_status, voice_position,
                 output ready);
endinterface

@@ rtl/multi_voice_sample_mixer.sv @@
// Stereo sample-playback mixer. Voice state (length, position, play and loop
// marks, flags) sits in a small single-port RAM, sample frames in a 64K x 32
// RAM, both with a registered read; the block handles one word at a time and
// walks the voices one by one through the voice RAM. A command word reads and
// writes its voice entry, a frame write first scales both samples by the gain,
// a voice reset rewrites each voice in use, and a render reads each voice in
// use and a frame for each playing voice that contributes, first reducing the
// position of a looping voice at or beyond its length. The response register
// lets the next word be accepted while a response waits to be taken. Frames
// that were never written read back as unknown data.
module multi_voice_sample_mixer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [mvsm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mvsm_pkg::CSR_DATA_W-1:0]      csr_wdata,
   mvsm_req_if.sink                             req_chan,
   mvsm_rsp_if.source                           rsp_chan
);

   typedef enum logic [15:0] {
      ST_IDLE     = 16'b0000000000000001,
      ST_GAIN_MUL = 16'b0000000000000010,
      ST_GAIN_REC = 16'b0000000000000100,
      ST_GAIN_DIV = 16'b0000000000001000,
      ST_GAIN_FIX = 16'b0000000000010000,
      ST_V_RD     = 16'b0000000000100000,
      ST_V_WR     = 16'b0000000001000000,
      ST_Z_RD     = 16'b0000000010000000,
      ST_Z_WR     = 16'b0000000100000000,
      ST_R_RD     = 16'b0000001000000000,
      ST_R_EVAL   = 16'b0000010000000000,
      ST_R_MOD    = 16'b0000100000000000,
      ST_R_FRD    = 16'b0001000000000000,
      ST_R_ACC    = 16'b0010000000000000,
      ST_F_RD     = 16'b0100000000000000,
      ST_F_OUT    = 16'b1000000000000000
   } state_type;

   localparam int VALUE_W  = mvsm_pkg::VALUE_W;
   localparam int SAMPLE_W = mvsm_pkg::SAMPLE_W;
   localparam int VOICE_W  = mvsm_pkg::VOICE_W;
   localparam int FIDX_W   = mvsm_pkg::FIDX_W;
   localparam int CNT_W    = mvsm_pkg::CNT_W;

   state_type state_ff, state_in;

   logic [mvsm_pkg::COUNT_W-1:0] count_ff;
   logic                         add_ff;
   logic [mvsm_pkg::GAIN_W-1:0]  gain_ff;

   logic [mvsm_pkg::MODE_W-1:0]  mode_ff;
   logic [mvsm_pkg::VNUM_W-1:0]  voice_ff;
   logic [VALUE_W-1:0]           value_ff;
   logic [mvsm_pkg::FLAGS_W-1:0] flags_ff;
   logic signed [SAMPLE_W-1:0]   acc_l_ff, acc_l_in, acc_r_ff, acc_r_in;
   logic                         first_ff, first_in;
   logic [CNT_W-1:0]             idx_ff, idx_in;
   mvsm_pkg::voice_entry_type    ent_ff, ent_in;
   logic [FIDX_W-1:0]            fidx_ff, fidx_in;
   logic [VALUE_W-1:0]           rem_ff, rem_in;
   logic [3:0]                   step_ff, step_in;

   logic signed [25:0]           prod_l_ff, prod_r_ff;
   logic [23:0]                  mag_l_ff, mag_r_ff;
   logic                         neg_l_ff, neg_r_ff;
   logic [17:0]                  q0_l_ff, q0_r_ff;

   // Voice state RAM with a valid bit per entry; an unwritten entry reads as zero.
   mvsm_pkg::voice_entry_type    vmem [mvsm_pkg::NUM_VOICES];
   logic [mvsm_pkg::NUM_VOICES-1:0] vvalid_ff;
   mvsm_pkg::voice_entry_type    vrdata_ff, rent;
   logic                         vrvalid_ff;
   logic [VOICE_W-1:0]           vaddr;
   logic                         vwe;
   mvsm_pkg::voice_entry_type    vwdata;

   logic [31:0]                  fmem [mvsm_pkg::NUM_VOICES * mvsm_pkg::FRAMES_PER_VOICE];
   logic [31:0]                  fdata_ff;
   logic [mvsm_pkg::FADDR_W-1:0] fraddr, fwaddr;
   logic                         fwe;
   logic [31:0]                  fwdata;

   logic                         rsp_valid_ff;
   logic signed [SAMPLE_W-1:0]   out_l_ff, out_r_ff;
   logic [mvsm_pkg::STATUS_W-1:0] out_st_ff;
   logic [VALUE_W-1:0]           out_pos_ff;
   logic                         out_load;

   logic [CNT_W-1:0]             inuse;
   logic                         inrange;
   logic                         voice_ok;
   logic                         last_voice;
   logic                         accept;
   logic [VALUE_W-1:0]           rem_shift;
   logic [FIDX_W:0]              fidx_inc;

   function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SAMPLE_W:0] d);
      logic signed [SAMPLE_W-1:0] r;
      if (d > 17'(mvsm_pkg::SAMPLE_MAX)) begin
         r = mvsm_pkg::SAMPLE_MAX;
      end else if (d < -17'(mvsm_pkg::SAMPLE_MAX)) begin
         r = -mvsm_pkg::SAMPLE_MAX;
      end else begin
         r = d[SAMPLE_W-1:0];
      end
      return r;
   endfunction

   // Finishes the divide by 100 and applies sign and the +-0x7fff limit.
   function automatic logic [SAMPLE_W-1:0] gain_fix(input logic [23:0] mag,
                                                    input logic [17:0] q0,
                                                    input logic neg);
      logic [24:0] rem;
      logic [17:0] q;
      logic [SAMPLE_W-1:0] m;
      rem = {1'b0, mag} - 25'(q0 * 7'(mvsm_pkg::GAIN_DIV));
      q = (rem >= 25'(mvsm_pkg::GAIN_DIV)) ? q0 + 18'd1 : q0;
      m = (q > 18'(mvsm_pkg::SAMPLE_MAX)) ? mvsm_pkg::SAMPLE_MAX : q[SAMPLE_W-1:0];
      return neg ? -m : m;
   endfunction

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rent           = vrvalid_ff ? vrdata_ff : '0;
   assign out_load       = (state_ff == ST_F_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      if (int'(count_ff) > mvsm_pkg::NUM_VOICES) begin
         inuse = CNT_W'(mvsm_pkg::NUM_VOICES);
      end else begin
         inuse = CNT_W'(count_ff);
      end
   end

   assign inrange    = int'(voice_ff) < int'(inuse);
   assign voice_ok   = int'(voice_ff) < mvsm_pkg::NUM_VOICES;
   assign last_voice = (idx_ff + CNT_W'(1)) == inuse;
   assign rem_shift  = {rem_ff[VALUE_W-2:0], ent_ff.pos[VALUE_W-1-int'(step_ff)]};
   assign fidx_inc   = {1'b0, fidx_ff} + (FIDX_W+1)'(1);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         add_ff   <= 1'b0;
         gain_ff  <= mvsm_pkg::GAIN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            mvsm_pkg::CSR_VOICE_COUNT:   count_ff <= csr_wdata[mvsm_pkg::COUNT_W-1:0];
            mvsm_pkg::CSR_ADD_TO_STREAM: add_ff   <= csr_wdata[0];
            mvsm_pkg::CSR_GAIN_PERCENT:  gain_ff  <= csr_wdata[mvsm_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      acc_l_in = acc_l_ff;
      acc_r_in = acc_r_ff;
      first_in = first_ff;
      idx_in   = idx_ff;
      ent_in   = ent_ff;
      fidx_in  = fidx_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      vaddr    = idx_ff[VOICE_W-1:0];
      vwe      = 1'b0;
      vwdata   = rent;
      fraddr   = {idx_ff[VOICE_W-1:0], fidx_ff};

      unique case (state_ff)
         ST_IDLE: begin
            vaddr = req_chan.voice[VOICE_W-1:0];
            if (accept) begin
               acc_l_in = req_chan.left_in;
               acc_r_in = req_chan.right_in;
               first_in = 1'b1;
               idx_in   = '0;
               unique case (req_chan.mode) inside
                  mvsm_pkg::MODE_WRITE: state_in = ST_GAIN_MUL;
                  mvsm_pkg::MODE_LENGTH, mvsm_pkg::MODE_PLAY, mvsm_pkg::MODE_PAUSE,
                  mvsm_pkg::MODE_RESUME, mvsm_pkg::MODE_STOP, mvsm_pkg::MODE_LOOP,
                  mvsm_pkg::MODE_POSITION: state_in = ST_V_RD;
                  mvsm_pkg::MODE_RESET:  state_in = (inuse == '0) ? ST_F_RD : ST_Z_RD;
                  mvsm_pkg::MODE_RENDER: state_in = (inuse == '0) ? ST_F_RD : ST_R_RD;
                  default: state_in = ST_F_RD;
               endcase
            end
         end
         ST_GAIN_MUL: state_in = ST_GAIN_REC;
         ST_GAIN_REC: state_in = ST_GAIN_DIV;
         ST_GAIN_DIV: state_in = ST_GAIN_FIX;
         ST_GAIN_FIX: state_in = ST_F_RD;
         ST_V_RD: begin
            vaddr    = voice_ff[VOICE_W-1:0];
            state_in = ST_V_WR;
         end
         ST_V_WR: begin
            vaddr    = voice_ff[VOICE_W-1:0];
            state_in = ST_F_RD;
            case (mode_ff)
               mvsm_pkg::MODE_LENGTH: begin
                  vwe = voice_ok;
                  vwdata.length  = (int'(value_ff) >= mvsm_pkg::FRAMES_PER_VOICE) ?
                                   VALUE_W'(mvsm_pkg::FRAMES_PER_VOICE) : value_ff;
                  vwdata.flags   = flags_ff;
                  vwdata.playing = 1'b0;
                  vwdata.pos     = '0;
               end
               mvsm_pkg::MODE_PLAY: begin
                  vwe = inrange && !rent.flags[mvsm_pkg::FLAG_IGNORE];
                  vwdata.playing = 1'b1;
                  vwdata.pos     = '0;
               end
               mvsm_pkg::MODE_PAUSE: begin
                  vwe = inrange;
                  vwdata.playing = 1'b0;
               end
               mvsm_pkg::MODE_RESUME: begin
                  vwe = inrange;
                  vwdata.playing = 1'b1;
               end
               mvsm_pkg::MODE_STOP: begin
                  vwe = inrange;
                  vwdata.playing = 1'b0;
                  vwdata.pos     = '0;
               end
               mvsm_pkg::MODE_LOOP: begin
                  vwe = inrange && !rent.flags[mvsm_pkg::FLAG_NOLOOP];
                  vwdata.looping = value_ff[0];
               end
               mvsm_pkg::MODE_POSITION: begin
                  vwe = inrange;
                  vwdata.pos = value_ff;
               end
               default: ;
            endcase
         end
         ST_Z_RD: state_in = ST_Z_WR;
         ST_Z_WR: begin
            vwe = 1'b1;
            vwdata.playing = 1'b0;
            vwdata.pos     = '0;
            if (rent.flags[mvsm_pkg::FLAG_AUTOLOOP]) begin
               if (!rent.flags[mvsm_pkg::FLAG_NOLOOP]) begin
                  vwdata.looping = 1'b1;
               end
               if (!rent.flags[mvsm_pkg::FLAG_IGNORE]) begin
                  vwdata.playing = 1'b1;
               end
            end
            idx_in   = idx_ff + CNT_W'(1);
            state_in = last_voice ? ST_F_RD : ST_Z_RD;
         end
         ST_R_RD: state_in = ST_R_EVAL;
         ST_R_EVAL: begin
            ent_in  = rent;
            rem_in  = '0;
            step_in = '0;
            fidx_in = rent.pos[FIDX_W-1:0];
            if (!rent.playing) begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = last_voice ? ST_F_RD : ST_R_RD;
            end else if ((rent.looping && rent.length == '0) ||
                         (!rent.looping && rent.pos >= rent.length)) begin
               // A voice with nothing left to play stops here.
               vwe = 1'b1;
               vwdata.playing = 1'b0;
               idx_in   = idx_ff + CNT_W'(1);
               state_in = last_voice ? ST_F_RD : ST_R_RD;
            end else if (rent.pos >= rent.length) begin
               state_in = ST_R_MOD;
            end else begin
               state_in = ST_R_FRD;
            end
         end
         ST_R_MOD: begin
            // One restoring step of pos mod length per cycle, MSB first.
            rem_in  = (rem_shift >= ent_ff.length) ? rem_shift - ent_ff.length : rem_shift;
            step_in = step_ff + 4'd1;
            if (int'(step_ff) == VALUE_W - 1) begin
               fidx_in  = rem_in[FIDX_W-1:0];
               state_in = ST_R_FRD;
            end
         end
         ST_R_FRD: begin
            vwe    = 1'b1;
            vwdata = ent_ff;
            if (ent_ff.looping) begin
               vwdata.pos = (VALUE_W'(fidx_inc) == ent_ff.length) ? '0 : VALUE_W'(fidx_inc);
            end else begin
               vwdata.pos = VALUE_W'(fidx_inc);
            end
            state_in = ST_R_ACC;
         end
         ST_R_ACC: begin
            if (!add_ff && first_ff) begin
               acc_l_in = fdata_ff[SAMPLE_W-1:0];
               acc_r_in = fdata_ff[2*SAMPLE_W-1:SAMPLE_W];
            end else begin
               acc_l_in = sat16(17'(acc_l_ff) + 17'($signed(fdata_ff[SAMPLE_W-1:0])));
               acc_r_in = sat16(17'(acc_r_ff) +
                                17'($signed(fdata_ff[2*SAMPLE_W-1:SAMPLE_W])));
            end
            first_in = 1'b0;
            idx_in   = idx_ff + CNT_W'(1);
            state_in = last_voice ? ST_F_RD : ST_R_RD;
         end
         ST_F_RD: begin
            vaddr    = voice_ff[VOICE_W-1:0];
            state_in = ST_F_OUT;
         end
         ST_F_OUT: begin
            vaddr = voice_ff[VOICE_W-1:0];
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign fwe    = (state_ff == ST_GAIN_FIX) && voice_ok &&
                   (int'(value_ff) < mvsm_pkg::FRAMES_PER_VOICE);
   assign fwaddr = {voice_ff[VOICE_W-1:0], value_ff[FIDX_W-1:0]};
   assign fwdata = {gain_fix(mag_r_ff, q0_r_ff, neg_r_ff),
                    gain_fix(mag_l_ff, q0_l_ff, neg_l_ff)};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (vwe) begin
            vvalid_ff[vaddr] <= 1'b1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_chan.mode;
         voice_ff <= req_chan.voice;
         value_ff <= req_chan.value;
         flags_ff <= req_chan.voice_flags;
      end
      acc_l_ff <= acc_l_in;
      acc_r_ff <= acc_r_in;
      first_ff <= first_in;
      idx_ff   <= idx_in;
      ent_ff   <= ent_in;
      fidx_ff  <= fidx_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;

      prod_l_ff <= acc_l_ff * $signed({1'b0, gain_ff});
      prod_r_ff <= acc_r_ff * $signed({1'b0, gain_ff});
      neg_l_ff  <= prod_l_ff[25];
      neg_r_ff  <= prod_r_ff[25];
      mag_l_ff  <= prod_l_ff[25] ? 24'(-prod_l_ff) : prod_l_ff[23:0];
      mag_r_ff  <= prod_r_ff[25] ? 24'(-prod_r_ff) : prod_r_ff[23:0];
      q0_l_ff   <= 18'((50'(mag_l_ff) * 50'(mvsm_pkg::GAIN_RECIP)) >> 32);
      q0_r_ff   <= 18'((50'(mag_r_ff) * 50'(mvsm_pkg::GAIN_RECIP)) >> 32);

      if (out_load) begin
         out_l_ff   <= acc_l_ff;
         out_r_ff   <= acc_r_ff;
         out_st_ff  <= !inrange ? mvsm_pkg::STATUS_RANGE :
                       rent.playing ? mvsm_pkg::STATUS_PLAYING : mvsm_pkg::STATUS_IDLE;
         out_pos_ff <= inrange ? rent.pos : '0;
      end
   end

   // Voice RAM: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (vwe) begin
         vmem[vaddr] <= vwdata;
      end
      vrdata_ff  <= vmem[vaddr];
      vrvalid_ff <= vvalid_ff[vaddr];
   end

   // Frame RAM.
   always_ff @(posedge clock) begin
      if (fwe) begin
         fmem[fwaddr] <= fwdata;
      end
      fdata_ff <= fmem[fraddr];
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.left_out       = out_l_ff;
   assign rsp_chan.right_out      = out_r_ff;
   assign rsp_chan.voice_status   = out_st_ff;
   assign rsp_chan.voice_position = out_pos_ff;

endmodule

@@ rtl/mvsm_checker.sv @@
module mvsm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [mvsm_pkg::STATUS_W-1:0]       rsp_status,
   input logic [mvsm_pkg::VALUE_W-1:0]        rsp_position
);

   // A stalled response word stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // The block works on one word at a time, so ready drops after an accept.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word accepted while busy");

   // The status code never takes the unused value.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("unused status code");

   // A voice outside the range in use reports position zero.
   a_range_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == mvsm_pkg::STATUS_RANGE |-> rsp_position == '0)
      else $error("position reported for voice out of range");

endmodule

bind multi_voice_sample_mixer mvsm_checker u_mvsm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_status   (rsp_chan.voice_status),
   .rsp_position (rsp_chan.voice_position)
);

@@ test/multi_voice_sample_mixer_test.sv @@
module multi_voice_sample_mixer_test;
   import mvsm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [MODE_W-1:0]          mode;
      logic [VNUM_W-1:0]          voice;
      logic [VALUE_W-1:0]         value;
      logic [FLAGS_W-1:0]         flags;
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
   } command_word_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic [STATUS_W-1:0]        status;
      logic [VALUE_W-1:0]         position;
   } mix_word_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   mvsm_req_if req_chan ();
   mvsm_rsp_if rsp_chan ();

   multi_voice_sample_mixer uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   // Mirror of the mixer state, advanced as words are queued.
   logic [31:0]        frame_mem [NUM_VOICES][FRAMES_PER_VOICE];
   bit                 frame_set [NUM_VOICES][FRAMES_PER_VOICE];
   int                 voice_len [NUM_VOICES];
   int                 voice_at [NUM_VOICES];
   bit                 voice_on [NUM_VOICES];
   bit                 voice_wrap [NUM_VOICES];
   logic [FLAGS_W-1:0] voice_flag [NUM_VOICES];
   int                 count_reg;
   bit                 add_reg;
   int                 gain_reg;

   command_word_type commands_pending [$];
   mix_word_type     mixes_due [$];
   int               words_queued;
   bit               failed;
   bit               no_idling;

   bit req_fire;
   bit rsp_fire;
   int send_gap;
   int take_stall;

   function automatic logic [15:0] gain_scaled(int sample);
      int d;
      d = (sample * gain_reg) / GAIN_DIV;
      if (d > 32767) d = 32767;
      if (d < -32767) d = -32767;
      return d[15:0];
   endfunction

   function automatic int clamp_sum(int d);
      if (d > 32767) return 32767;
      if (d < -32767) return -32767;
      return d;
   endfunction

   function automatic mix_word_type mixer_outcome(command_word_type c);
      mix_word_type o;
      int in_use;
      int l;
      int r;
      int v;
      int idx;
      bit first;
      logic signed [15:0] fl;
      logic signed [15:0] fr;
      in_use = (count_reg < NUM_VOICES) ? count_reg : NUM_VOICES;
      v = c.voice;
      l = c.left;
      r = c.right;
      case (c.mode)
         MODE_WRITE: begin
            if (c.value < FRAMES_PER_VOICE) begin
               frame_mem[v][c.value] = {gain_scaled(c.right), gain_scaled(c.left)};
               frame_set[v][c.value] = 1;
            end
         end
         MODE_LENGTH: begin
            voice_len[v] = (c.value < FRAMES_PER_VOICE) ? c.value : FRAMES_PER_VOICE;
            voice_flag[v] = c.flags;
            voice_on[v] = 0;
            voice_at[v] = 0;
         end
         MODE_PLAY: if (v < in_use && !voice_flag[v][FLAG_IGNORE]) begin
            voice_on[v] = 1;
            voice_at[v] = 0;
         end
         MODE_PAUSE: if (v < in_use) voice_on[v] = 0;
         MODE_RESUME: if (v < in_use) voice_on[v] = 1;
         MODE_STOP: if (v < in_use) begin
            voice_on[v] = 0;
            voice_at[v] = 0;
         end
         MODE_LOOP: if (v < in_use && !voice_flag[v][FLAG_NOLOOP]) voice_wrap[v] = c.value[0];
         MODE_POSITION: if (v < in_use) voice_at[v] = c.value;
         MODE_RESET: begin
            for (int i = 0; i < in_use; i++) begin
               voice_on[i] = 0;
               voice_at[i] = 0;
               if (voice_flag[i][FLAG_AUTOLOOP]) begin
                  if (!voice_flag[i][FLAG_NOLOOP]) voice_wrap[i] = 1;
                  if (!voice_flag[i][FLAG_IGNORE]) voice_on[i] = 1;
               end
            end
         end
         MODE_RENDER: begin
            first = 1;
            for (int i = 0; i < in_use; i++) begin
               if (!voice_on[i]) continue;
               if (voice_wrap[i]) begin
                  if (voice_len[i] == 0) begin
                     voice_on[i] = 0;
                     continue;
                  end
                  idx = voice_at[i] % voice_len[i];
                  voice_at[i] = (idx + 1) % voice_len[i];
               end else begin
                  if (voice_at[i] >= voice_len[i]) begin
                     voice_on[i] = 0;
                     continue;
                  end
                  idx = voice_at[i];
                  voice_at[i] = idx + 1;
               end
               fl = frame_mem[i][idx][15:0];
               fr = frame_mem[i][idx][31:16];
               if (!add_reg && first) begin
                  l = fl;
                  r = fr;
               end else begin
                  l = clamp_sum(l + fl);
                  r = clamp_sum(r + fr);
               end
               first = 0;
            end
         end
         default: ;
      endcase
      o.left = l[15:0];
      o.right = r[15:0];
      if (v < in_use) begin
         o.status = voice_on[v] ? STATUS_PLAYING : STATUS_IDLE;
         o.position = voice_at[v][VALUE_W-1:0];
      end else begin
         o.status = STATUS_RANGE;
         o.position = '0;
      end
      return o;
   endfunction

   function automatic logic [15:0] any_sample();
      case ($urandom_range(0, 5))
         0: return 16'h7fff;
         1: return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic queue_word(command_word_type c);
      mixes_due.push_back(mixer_outcome(c));
      commands_pending.push_back(c);
      words_queued++;
   endtask

   // Every frame a render will read must have been written first, so missing
   // frames are filled in just ahead of the render word.
   task automatic queue_command(logic [MODE_W-1:0] m, int v, int value, int fl,
                                logic [15:0] l, logic [15:0] r);
      command_word_type c;
      command_word_type w;
      int in_use;
      int idx;
      in_use = (count_reg < NUM_VOICES) ? count_reg : NUM_VOICES;
      if (m == MODE_RENDER) begin
         for (int i = 0; i < in_use; i++) begin
            if (!voice_on[i]) continue;
            if (voice_wrap[i]) begin
               if (voice_len[i] == 0) continue;
               idx = voice_at[i] % voice_len[i];
            end else begin
               if (voice_at[i] >= voice_len[i]) continue;
               idx = voice_at[i];
            end
            if (!frame_set[i][idx]) begin
               w = '{MODE_WRITE, i[3:0], idx[12:0], 3'($urandom), any_sample(), any_sample()};
               queue_word(w);
            end
         end
      end
      c = '{m, v[3:0], value[12:0], fl[2:0], l, r};
      queue_word(c);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, int data);
      while (commands_pending.size() != 0 || mixes_due.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= data[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_we <= 0;
      case (idx)
         CSR_VOICE_COUNT: count_reg = data & 5'h1f;
         CSR_ADD_TO_STREAM: add_reg = data[0];
         default: gain_reg = data & 9'h1ff;
      endcase
   endtask

   task automatic queue_phrase();
      int v;
      int len;
      int flags;
      int renders;
      v = $urandom_range(0, 15);
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 8191) : $urandom_range(0, 6);
      flags = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 7);
      for (int i = 0; i < len && i < 6; i++)
         queue_command(MODE_WRITE, v, i, 0, any_sample(), any_sample());
      queue_command(MODE_LENGTH, v, len, flags, any_sample(), any_sample());
      if ($urandom_range(0, 1) != 0)
         queue_command(MODE_LOOP, v, $urandom_range(0, 1), 0, any_sample(), any_sample());
      queue_command(($urandom_range(0, 4) == 0) ? MODE_RESET : MODE_PLAY, v, 0, 0,
                    any_sample(), any_sample());
      renders = $urandom_range(1, 9);
      for (int i = 0; i < renders; i++) begin
         case ($urandom_range(0, 9))
            0: queue_command(MODE_PAUSE, v, 0, 0, any_sample(), any_sample());
            1: queue_command(MODE_RESUME, v, 0, 0, any_sample(), any_sample());
            2: queue_command(MODE_POSITION, v, $urandom_range(0, 9), 0,
                             any_sample(), any_sample());
            3: queue_command(MODE_QUERY, v, $urandom, 0, any_sample(), any_sample());
            default: ;
         endcase
         queue_command(MODE_RENDER, v, $urandom, $urandom, any_sample(), any_sample());
      end
   endtask

   task automatic queue_noise();
      queue_command(4'($urandom_range(0, 15)), $urandom_range(0, 15),
                    ($urandom_range(0, 1) != 0) ? $urandom_range(0, 8191) : $urandom_range(0, 7),
                    $urandom_range(0, 7), any_sample(), any_sample());
   endtask

   initial begin
      clock = 0;
      reset = 1;
      csr_we = 0;
      csr_index = '0;
      csr_wdata = '0;
      req_chan.valid = 0;
      req_chan.mode = '0;
      req_chan.voice = '0;
      req_chan.value = '0;
      req_chan.voice_flags = '0;
      req_chan.left_in = '0;
      req_chan.right_in = '0;
      rsp_chan.ready = 0;
      forever #10 clock = ~clock;
   end

   // Request driver: holds a word until it is taken, then stays idle for a gap
   // drawn at random (none when no_idling is set) before offering the next one.
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 0;
         send_gap <= 0;
      end else if (req_chan.valid && !req_fire) begin
      end else if (send_gap != 0) begin
         req_chan.valid <= 0;
         send_gap <= send_gap - 1;
      end else if (commands_pending.size() != 0) begin
         command_word_type c;
         c = commands_pending.pop_front();
         req_chan.valid <= 1;
         req_chan.mode <= c.mode;
         req_chan.voice <= c.voice;
         req_chan.value <= c.value;
         req_chan.voice_flags <= c.flags;
         req_chan.left_in <= c.left;
         req_chan.right_in <= c.right;
         send_gap <= no_idling ? 0 : $urandom_range(0, 9);
      end else begin
         req_chan.valid <= 0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 0;
         take_stall <= 0;
      end else if (rsp_fire) begin
         int stall;
         stall = no_idling ? 0 : $urandom_range(0, 9);
         take_stall <= stall;
         rsp_chan.ready <= (stall == 0);
      end else if (take_stall > 1) begin
         take_stall <= take_stall - 1;
      end else begin
         take_stall <= 0;
         rsp_chan.ready <= 1;
      end
   end

   always @(posedge clock) begin
      req_fire <= req_chan.valid && req_chan.ready;
      rsp_fire <= rsp_chan.valid && rsp_chan.ready;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         mix_word_type got;
         mix_word_type want;
         got = '{rsp_chan.left_out, rsp_chan.right_out, rsp_chan.voice_status,
                 rsp_chan.voice_position};
         if (mixes_due.size() == 0) begin
            $display("%0t: unexpected word: left %0d right %0d status %0d position %0d",
                     $time, got.left, got.right, got.status, got.position);
            failed = 1;
         end else begin
            want = mixes_due.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch: expected left %0d right %0d status %0d position %0d",
                        $time, want.left, want.right, want.status, want.position);
               $display("%0t:           actual left %0d right %0d status %0d position %0d",
                        $time, got.left, got.right, got.status, got.position);
               failed = 1;
            end
         end
      end
   end

   initial begin
      int settings [8][3];
      settings = '{'{16, 0, 100}, '{16, 1, 400}, '{3, 0, 0}, '{0, 1, 100},
                   '{31, 0, 511}, '{9, 1, 57}, '{16, 0, 250}, '{5, 1, 100}};
      failed = 0;
      no_idling = 0;
      words_queued = 0;
      count_reg = 0;
      add_reg = 0;
      gain_reg = GAIN_RESET;
      for (int i = 0; i < NUM_VOICES; i++) begin
         voice_len[i] = 0;
         voice_at[i] = 0;
         voice_on[i] = 0;
         voice_wrap[i] = 0;
         voice_flag[i] = '0;
         for (int j = 0; j < FRAMES_PER_VOICE; j++) frame_set[i][j] = 0;
      end
      repeat (3) @(negedge clock);
      reset <= 0;

      // A few words with no voice in use, so every voice is out of range.
      queue_command(MODE_QUERY, 0, 0, 0, 16'h7fff, 16'h8000);
      queue_command(MODE_PLAY, 15, 0, 0, 16'h0001, 16'hffff);
      write_register(CSR_VOICE_COUNT, 16);
      write_register(CSR_ADD_TO_STREAM, 0);
      write_register(CSR_GAIN_PERCENT, 100);
      queue_command(MODE_WRITE, 0, 0, 0, 16'h7fff, 16'h8000);
      queue_command(MODE_WRITE, 15, 4095, 0, 16'h8000, 16'h7fff);
      queue_command(MODE_WRITE, 3, 4096, 0, 16'h1234, 16'h4321);
      queue_command(MODE_WRITE, 0, 1, 0, 16'h7000, 16'h9000);
      queue_command(MODE_LENGTH, 0, 2, 0, 0, 0);
      queue_command(MODE_PLAY, 0, 0, 0, 0, 0);
      queue_command(MODE_RENDER, 0, 0, 0, 16'h7fff, 16'h8000);
      queue_command(MODE_RENDER, 0, 0, 0, 0, 0);
      queue_command(MODE_RENDER, 0, 0, 0, 16'h0005, 16'hfffb);
      queue_command(MODE_LENGTH, 15, 8191, 4'h6, 0, 0);
      queue_command(MODE_LOOP, 15, 1, 0, 0, 0);
      queue_command(MODE_POSITION, 15, 8191, 0, 0, 0);
      queue_command(MODE_RESUME, 15, 0, 0, 0, 0);
      queue_command(MODE_RENDER, 0, 0, 0, 0, 0);
      queue_command(MODE_PAUSE, 15, 0, 0, 0, 0);
      queue_command(MODE_STOP, 15, 0, 0, 0, 0);
      queue_command(MODE_LENGTH, 15, 3, 4'h5, 0, 0);
      queue_command(MODE_RESET, 0, 0, 0, 0, 0);
      queue_command(MODE_LOOP, 15, 1, 0, 0, 0);
      queue_command(MODE_RENDER, 15, 0, 0, 16'h7fff, 16'h7fff);
      queue_command(4'd15, 15, 8191, 7, 16'h8000, 16'h8000);

      // Random phases, each under its own register setting.
      for (int p = 0; p < 8; p++) begin
         write_register(CSR_VOICE_COUNT, settings[p][0]);
         write_register(CSR_ADD_TO_STREAM, settings[p][1]);
         write_register(CSR_GAIN_PERCENT, settings[p][2]);
         no_idling = (p % 3 == 2);
         while (words_queued < 150 * (p + 1)) begin
            if ($urandom_range(0, 9) < 7) queue_phrase();
            else queue_noise();
         end
      end

      while (commands_pending.size() != 0 || mixes_due.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (!failed) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #60ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
